// File: rtl/utw8_pkg.sv
// Package for the UTF-16 to WTF-8/UTF-8/CESU-8 encoder.
// Holds mode codes, queue sizing, the job record and byte encoding functions.
// No dependencies.
package utw8_pkg;

  localparam logic [1:0] MODE_WTF8  = 2'd0;
  localparam logic [1:0] MODE_UTF8  = 2'd1;
  localparam logic [1:0] MODE_CESU8 = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int CFG_AW = 3;
  localparam logic CFG_IDX_MODE = 1'b0;

  localparam logic [15:0] LEAD_LO  = 16'hd800;
  localparam logic [15:0] LEAD_HI  = 16'hdbff;
  localparam logic [15:0] TRAIL_LO = 16'hdc00;
  localparam logic [15:0] TRAIL_HI = 16'hdfff;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] REPL_CHAR = 21'h0fffd;

  typedef struct packed {
    logic        b_vld;
    logic        zero_long;
    logic [20:0] a_cp;
    logic [20:0] b_cp;
  } job_t;

  typedef struct packed {
    logic vld;
    job_t job;
  } q_head_t;

  function automatic logic is_lead(input logic [15:0] u);
    return (u >= LEAD_LO) && (u <= LEAD_HI);
  endfunction

  function automatic logic is_trail(input logic [15:0] u);
    return (u >= TRAIL_LO) && (u <= TRAIL_HI);
  endfunction

  function automatic logic is_surr(input logic [15:0] u);
    return (u >= LEAD_LO) && (u <= TRAIL_HI);
  endfunction

  function automatic logic [20:0] alone_cp(input logic [1:0] mode, input logic [15:0] u);
    if (mode == MODE_UTF8 && is_surr(u)) begin
      return REPL_CHAR;
    end
    return {5'd0, u};
  endfunction

  function automatic logic [1:0] enc_last_idx(input logic [20:0] cp, input logic zl);
    if (cp == 21'd0 && zl) return 2'd1;
    if (cp < 21'h80)       return 2'd0;
    if (cp < 21'h800)      return 2'd1;
    if (cp < 21'h10000)    return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic zl,
                                          input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (cp == 21'd0 && zl) begin
      b = (idx == 2'd0) ? 8'hc0 : 8'h80;
    end else if (cp < 21'h80) begin
      b = cp[7:0];
    end else if (cp < 21'h800) begin
      case (idx)
        2'd0:    b = {3'b110, cp[10:6]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end else if (cp < 21'h10000) begin
      case (idx)
        2'd0:    b = {4'b1110, cp[15:12]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end else begin
      case (idx)
        2'd0:    b = {5'b11110, cp[20:18]};
        2'd1:    b = {2'b10, cp[17:12]};
        2'd2:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end
    return b;
  endfunction

endpackage

// File: rtl/utw8_in_if.sv
// Input channel: one UTF-16 code unit word per handshake.
// Depends on nothing.
interface utw8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source(output valid, output code_unit, output last_unit, input ready);
  modport sink(input valid, input code_unit, input last_unit, output ready);
endinterface

// File: rtl/utw8_out_if.sv
// Output channel: one encoded byte word per handshake.
// Depends on nothing.
interface utw8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source(output valid, output out_byte, output last_of_run, input ready);
  modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/utw8_front.sv
// Front end: accepts code units, holds the pending unit, pairs surrogates
// and pushes code point jobs into the queue. Depends on utw8_pkg, utw8_in_if.
module utw8_front (
  input  logic            clk,
  input  logic            rst_n,
  utw8_in_if.sink         in_ch,
  input  logic [1:0]      mode,
  input  logic            q_full,
  output logic            q_push,
  output utw8_pkg::job_t  q_data
);

  logic        pv_r, pv_nxt;
  logic [15:0] pu_r, pu_nxt;
  logic        accept;
  logic [15:0] u;
  logic [20:0] pair_cp;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign u           = in_ch.code_unit;
  assign pair_cp     = {1'b0, pu_r[9:0], u[9:0]} + utw8_pkg::SUPP_BASE;

  always_comb begin
    pv_nxt           = pv_r;
    pu_nxt           = pu_r;
    q_push           = 1'b0;
    q_data.b_vld     = 1'b0;
    q_data.zero_long = (mode == utw8_pkg::MODE_CESU8);
    q_data.a_cp      = utw8_pkg::alone_cp(mode, u);
    q_data.b_cp      = utw8_pkg::alone_cp(mode, u);
    if (accept) begin
      if (mode == utw8_pkg::MODE_CESU8) begin
        q_push = 1'b1;
        pv_nxt = 1'b0;
        if (pv_r) begin
          q_data.a_cp  = utw8_pkg::alone_cp(mode, pu_r);
          q_data.b_vld = 1'b1;
        end
      end else if (!pv_r) begin
        if (in_ch.last_unit) begin
          q_push = 1'b1;
        end else begin
          pv_nxt = 1'b1;
          pu_nxt = u;
        end
      end else if (utw8_pkg::is_lead(pu_r) && utw8_pkg::is_trail(u)) begin
        q_push      = 1'b1;
        q_data.a_cp = pair_cp;
        pv_nxt      = 1'b0;
      end else begin
        q_push      = 1'b1;
        q_data.a_cp = utw8_pkg::alone_cp(mode, pu_r);
        if (in_ch.last_unit) begin
          q_data.b_vld = 1'b1;
          pv_nxt       = 1'b0;
        end else begin
          pu_nxt = u;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      pu_r <= 16'd0;
    end else begin
      pv_r <= pv_nxt;
      pu_r <= pu_nxt;
    end
  end

endmodule

// File: rtl/utw8_fifo.sv
// Short job queue between front and back ends.
// Depends on utw8_pkg.
module utw8_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utw8_pkg::job_t    push_data,
  output logic              full,
  input  logic              pop,
  output utw8_pkg::q_head_t head
);

  utw8_pkg::job_t          mem_r [utw8_pkg::QDEPTH];
  logic [utw8_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [utw8_pkg::QAW:0]   cnt_r;
  logic                     do_pop;

  assign full     = (cnt_r == (utw8_pkg::QAW+1)'(utw8_pkg::QDEPTH));
  assign head.vld = (cnt_r != '0);
  assign head.job = mem_r[rd_ptr_r];
  assign do_pop   = pop && head.vld;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/utw8_back.sv
// Back end: serializes queued code point jobs into bytes, one per cycle while
// out_ch is ready, through an output register. Depends on utw8_pkg, utw8_out_if.
module utw8_back (
  input  logic              clk,
  input  logic              rst_n,
  input  utw8_pkg::q_head_t head,
  output logic              pop,
  utw8_out_if.source        out_ch
);

  logic           busy_r, busy_nxt;
  utw8_pkg::job_t rec_r, rec_nxt;
  logic           half_r, half_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r, out_last_nxt;

  utw8_pkg::job_t cur;
  logic           cur_vld, adv, fire, end_cp, done, half;
  logic [1:0]     idx;
  logic [20:0]    cp;

  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;

  assign adv     = !out_vld_r || out_ch.ready;
  assign cur     = busy_r ? rec_r : head.job;
  assign cur_vld = busy_r || head.vld;
  assign half    = busy_r && half_r;
  assign idx     = busy_r ? idx_r : 2'd0;
  assign cp      = half ? cur.b_cp : cur.a_cp;
  assign end_cp  = (idx == utw8_pkg::enc_last_idx(cp, cur.zero_long));
  assign done    = end_cp && (half || !cur.b_vld);
  assign fire    = adv && cur_vld;
  assign pop     = adv && !busy_r && head.vld;

  always_comb begin
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    busy_nxt     = busy_r;
    rec_nxt      = rec_r;
    half_nxt     = half_r;
    idx_nxt      = idx_r;
    if (fire) begin
      out_vld_nxt  = 1'b1;
      out_byte_nxt = utw8_pkg::enc_byte(cp, cur.zero_long, idx);
      out_last_nxt = done;
      busy_nxt     = !done;
      rec_nxt      = cur;
      if (end_cp) begin
        idx_nxt  = 2'd0;
        half_nxt = 1'b1;
      end else begin
        idx_nxt  = idx + 2'd1;
        half_nxt = half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
      half_r    <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
      half_r    <= half_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r      <= rec_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// File: rtl/utf16_to_wtf8_encoder_top.sv
// Path: the first byte of a unit that releases bytes passes through a job queue entry
// and then the output register before it is valid on out_ch.
// Throughput: one unit per cycle into a 4-entry job queue unless full; the back end
// emits one byte per cycle while out_ch is ready; a unit releases 0 to 6 bytes.
// Reset: synchronous active-low rst_n clears mode to WTF-8, the pending unit,
// the job queue and the output register.
module utf16_to_wtf8_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  utw8_in_if.sink                       in_ch,
  utw8_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [utw8_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [1:0]        mode_r;
  logic              q_full, q_push, q_pop;
  utw8_pkg::job_t    q_data;
  utw8_pkg::q_head_t q_head;
  logic              cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == utw8_pkg::CFG_IDX_MODE);
  assign cfg_prdata = cfg_hit ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= utw8_pkg::MODE_WTF8;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      mode_r <= cfg_pwdata[1:0];
    end
  end

  utw8_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .mode   (mode_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  utw8_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  utw8_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for utf16_to_wtf8_encoder_top: feeds UTF-16 code unit words and
// checks every encoded byte word against typed bytes or an in-bench transcoder predictor.
// Depends on utw8_pkg, utw8_in_if, utw8_out_if and the encoder RTL.
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PREDICT = -1;
  localparam int PHASE_UNITS = 30;
  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam logic [utw8_pkg::CFG_AW-1:0] MODE_ADDR =
    (utw8_pkg::CFG_AW)'(4 * utw8_pkg::CFG_IDX_MODE);
  localparam logic [utw8_pkg::CFG_AW-1:0] SPARE_ADDR = (utw8_pkg::CFG_AW)'(4);

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
  } enc_byte_t;

  typedef struct packed {
    bit          set_mode;
    logic [1:0]  mode;
    logic [15:0] cu;
    bit          lu;
    int          n;
    logic [47:0] bytes;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [utw8_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  utw8_in_if in_ch ();
  utw8_out_if out_ch ();

  utf16_to_wtf8_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // transcoder state
  logic [1:0]  cur_mode;
  logic [15:0] held_unit;
  logic        held_vld;
  logic [7:0]  run_bytes[$];
  enc_byte_t   owed_bytes[$];

  int err_count = 0;
  int cycles = 0;
  int units_sent = 0;
  int burst_left = 0;
  int stall_span = 0;
  int stall_pct = 0;

  dir_row_t dir_rows[26];

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    run_bytes = {run_bytes, b};
  endfunction

  function automatic void owe_byte(input logic [7:0] b, input logic lst);
    enc_byte_t e;
    e.b = b;
    e.lst = lst;
    owed_bytes = {owed_bytes, e};
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp, input logic zero_long);
    if (cp == 21'd0 && zero_long) begin
      add_byte(8'hc0);
      add_byte(8'h80);
    end else if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte(8'hc0 | 8'(cp >> 6));
      add_byte(8'h80 | 8'(cp & 21'h3f));
    end else if (cp < 21'h10000) begin
      add_byte(8'he0 | 8'(cp >> 12));
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
      add_byte(8'h80 | 8'(cp & 21'h3f));
    end else begin
      add_byte(8'hf0 | 8'((cp >> 18) & 21'h07));
      add_byte(8'h80 | 8'((cp >> 12) & 21'h3f));
      add_byte(8'h80 | 8'((cp >> 6) & 21'h3f));
      add_byte(8'h80 | 8'(cp & 21'h3f));
    end
  endfunction

  function automatic void emit_alone(input logic [15:0] u);
    if (cur_mode == utw8_pkg::MODE_CESU8) begin
      emit_code_point({5'd0, u}, 1'b1);
    end else if (cur_mode == utw8_pkg::MODE_UTF8 && u >= 16'hd800 && u <= 16'hdfff) begin
      emit_code_point(21'h0fffd, 1'b0);
    end else begin
      emit_code_point({5'd0, u}, 1'b0);
    end
  endfunction

  function automatic void transcode_unit(input logic [15:0] u, input logic lst);
    logic [20:0] cp;
    run_bytes.delete();
    if (cur_mode == utw8_pkg::MODE_CESU8) begin
      if (held_vld) begin
        emit_alone(held_unit);
        held_vld = 1'b0;
        held_unit = '0;
      end
      emit_alone(u);
    end else begin
      if (!held_vld) begin
        held_unit = u;
        held_vld = 1'b1;
      end else if (held_unit >= 16'hd800 && held_unit <= 16'hdbff &&
                   u >= 16'hdc00 && u <= 16'hdfff) begin
        cp = 21'h10000 + (({5'd0, held_unit} - 21'hd800) << 10) + ({5'd0, u} - 21'hdc00);
        emit_code_point(cp, 1'b0);
        held_vld = 1'b0;
        held_unit = '0;
      end else begin
        emit_alone(held_unit);
        held_unit = u;
      end
      if (lst && held_vld) begin
        emit_alone(held_unit);
        held_vld = 1'b0;
        held_unit = '0;
      end
    end
  endfunction

  task automatic send_unit(input logic [15:0] cu, input logic lu, input int n_typed,
                           input logic [47:0] typed);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.code_unit <= cu;
    in_ch.last_unit <= lu;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    units_sent++;
    transcode_unit(cu, lu);
    if (n_typed == PREDICT) begin
      for (int i = 0; i < run_bytes.size(); i++) begin
        owe_byte(run_bytes[i], (i == run_bytes.size() - 1));
      end
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        owe_byte(typed[47 - 8 * i -: 8], (i == n_typed - 1));
      end
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (owed_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [utw8_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == MODE_ADDR) begin
      cur_mode = data[1:0];
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_mode(input logic [1:0] m);
    logic [31:0] wd;
    wd = $urandom();
    wd[1:0] = m;
    write_reg(MODE_ADDR, wd);
  endtask

  task automatic send_string();
    logic [15:0] units[$];
    logic [15:0] u;
    int len;
    int kind;
    bit noisy;
    len = $urandom_range(1, 8);
    noisy = ($urandom_range(0, 9) == 0);
    while (units.size() < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        u = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom_range(1, 'h7f));
      end else if (kind < 45) begin
        u = 16'($urandom_range('h80, 'h7ff));
      end else if (kind < 65) begin
        u = 16'($urandom_range('h800, 'hf7ff));
        if (u >= 16'hd800) u = u + 16'h0800;
      end else if (kind < 85) begin
        u = 16'($urandom_range('hd800, 'hdbff));
        units = {units, u};
        u = 16'($urandom_range('hdc00, 'hdfff));
      end else if (kind < 92) begin
        u = 16'($urandom_range('hd800, 'hdfff));
      end else begin
        u = 16'($urandom());
      end
      units = {units, u};
    end
    for (int i = 0; i < units.size(); i++) begin
      send_unit(units[i], noisy ? 1'($urandom_range(0, 1)) : (i == units.size() - 1),
                PREDICT, '0);
    end
  endtask

  // receiver stall pattern: spans of fixed stall odds
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(8, 64);
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        default: stall_pct = 60;
      endcase
    end
    stall_span--;
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : byte_check
    enc_byte_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte %h last %b", out_ch.out_byte,
                                out_ch.last_of_run));
      end else begin
        w = owed_bytes.pop_front();
        if (out_ch.out_byte !== w.b) begin
          flag_mismatch($sformatf("out_byte %h, want %h", out_ch.out_byte, w.b));
        end
        if (out_ch.last_of_run !== w.lst) begin
          flag_mismatch($sformatf("last_of_run %b, want %b (byte %h)", out_ch.last_of_run,
                                  w.lst, w.b));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [1:0] phase_modes[4];
    int start;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.code_unit = '0;
    in_ch.last_unit = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cur_mode = utw8_pkg::MODE_WTF8;
    held_unit = '0;
    held_vld = 1'b0;
    phase_modes = '{utw8_pkg::MODE_CESU8, utw8_pkg::MODE_WTF8, MODE_RSVD,
                    utw8_pkg::MODE_UTF8};

    dir_rows = '{
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h0000, 1'b1, 1,       48'h00_0000000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h007f, 1'b1, 1,       48'h7f_0000000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h0080, 1'b1, 2,       48'hc280_00000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h07ff, 1'b1, 2,       48'hdfbf_00000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h0800, 1'b1, 3,       48'he0a080_000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hffff, 1'b1, 3,       48'hefbfbf_000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hd800, 1'b0, 0,       48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdc00, 1'b1, 4,       48'hf0908080_0000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdbff, 1'b0, 0,       48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdfff, 1'b1, 4,       48'hf48fbfbf_0000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hd800, 1'b1, 3,       48'heda080_000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdfff, 1'b1, 3,       48'hedbfbf_000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h0041, 1'b0, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h0042, 1'b0, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hd800, 1'b0, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h0043, 1'b1, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdbff, 1'b0, PREDICT, 48'h0},
      '{1'b1, utw8_pkg::MODE_UTF8,  16'h0041, 1'b1, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdc00, 1'b1, 3,       48'hefbfbd_000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hd800, 1'b0, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdc00, 1'b1, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'h00e9, 1'b0, PREDICT, 48'h0},
      '{1'b1, utw8_pkg::MODE_CESU8, 16'h0000, 1'b0, PREDICT, 48'h0},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hd800, 1'b0, 3,       48'heda080_000000},
      '{1'b0, utw8_pkg::MODE_WTF8,  16'hdc00, 1'b1, 3,       48'hedb080_000000},
      '{1'b1, MODE_RSVD,            16'hd800, 1'b1, 3,       48'heda080_000000}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_mode) begin
        release_input();
        wait_drained();
        set_mode(dir_rows[i].mode);
      end
      send_unit(dir_rows[i].cu, dir_rows[i].lu, dir_rows[i].n, dir_rows[i].bytes);
    end

    foreach (phase_modes[p]) begin
      release_input();
      wait_drained();
      if (p == 1) begin
        write_reg(SPARE_ADDR, $urandom());
      end
      set_mode(phase_modes[p]);
      start = units_sent;
      while (units_sent - start < PHASE_UNITS) send_string();
    end

    release_input();
    wait_drained();
    if (err_count == 0 && owed_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: utf16_to_wtf8_encoder_top.f
rtl/utw8_pkg.sv
rtl/utw8_in_if.sv
rtl/utw8_out_if.sv
rtl/utw8_front.sv
rtl/utw8_fifo.sv
rtl/utw8_back.sv
rtl/utf16_to_wtf8_encoder_top.sv
tb/tb_top.sv
